[hdl/tmbc_pkg.sv]
// Shared types and constants for the tile map box collision unit.
// No dependencies; used by tmbc_div, tmbc_map and the top level.
package tmbc_pkg;

  // Item opcodes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Register indexes (byte address bit 2)
  localparam logic REG_STAGE_COLS = 1'b0;
  localparam logic REG_STAGE_ROWS = 1'b1;

  // Field and bus widths
  localparam int POS_W      = 13;  // signed box position
  localparam int POS_MAG_W  = 12;  // position magnitude when non-negative
  localparam int TILE_IDX_W = 12;  // tile index carried to the map store
  localparam int MAP_IDX_W  = 6;   // tile column/row of a write beat
  localparam int OVL_W      = 5;   // overlap result width
  localparam int CFG_W      = 7;   // stage size register width
  localparam int SIZE_W     = 9;   // effective stage size, up to 256
  localparam int CFG_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  // Reciprocal divider: q = (x * floor(2^SHIFT / tile)) >> SHIFT, then one fixup
  localparam int RECIP_SHIFT = 24;
  localparam int RECIP_W     = 24;
  localparam int DIV_LATENCY = 3;

  // Map store write request
  typedef struct packed {
    logic                 en;
    logic [MAP_IDX_W-1:0] col;
    logic [MAP_IDX_W-1:0] row;
    logic                 solid;
  } map_wr_t;

  // Control carried alongside the divider pipeline
  typedef struct packed {
    logic                 op;
    logic                 neg_x;
    logic                 neg_y;
    logic [MAP_IDX_W-1:0] col;
    logic [MAP_IDX_W-1:0] row;
    logic                 solid;
  } item_ctrl_t;

endpackage

[hdl/tile_map_box_collision_unit.sv]
// Top level of the tile map box collision unit: APB registers, item pipeline, result stage.
// Depends on tmbc_pkg, tmbc_div and tmbc_map.
//
// One item (map write or box query) is taken per clock whenever busy is low. A query
// yields one result beat, with done high for one cycle; map writes yield none. Between
// the edge that accepted start and done lie the input register, the three-stage
// reciprocal divider that splits x and y into tile index and offset, the registered
// read of the four parity banks of the map, and the output register. Writes take effect
// in pipeline order, so a query sees every write accepted before it. After reset the
// map store is swept clear, one address of each bank per cycle, over all 2^(CHW + RHW)
// addresses of tmbc_map (1024 at the defaults); busy is high during that sweep and low
// otherwise. Results cannot be held off.
module tile_map_box_collision_unit #(
  parameter int TILE_SUBPIXELS = 16,
  parameter int MAX_COLS       = 64,
  parameter int MAX_ROWS       = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  // item beat
  input  logic                               start,
  output logic                               busy,
  input  logic                               op,
  input  logic [tmbc_pkg::MAP_IDX_W-1:0]     tile_col,
  input  logic [tmbc_pkg::MAP_IDX_W-1:0]     tile_row,
  input  logic                               tile_solid,
  input  logic signed [tmbc_pkg::POS_W-1:0]  box_x,
  input  logic signed [tmbc_pkg::POS_W-1:0]  box_y,
  // result beat
  output logic                               done,
  output logic                               blocked,
  output logic [tmbc_pkg::OVL_W-1:0]         left_overlap,
  output logic [tmbc_pkg::OVL_W-1:0]         right_overlap,
  output logic [tmbc_pkg::OVL_W-1:0]         top_overlap,
  output logic [tmbc_pkg::OVL_W-1:0]         bottom_overlap,
  // configuration
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [tmbc_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [tmbc_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [tmbc_pkg::APB_DATA_W-1:0]    prdata,
  output logic                               pready
);

  localparam int QW    = $clog2(((1 << tmbc_pkg::POS_MAG_W) - 1) / TILE_SUBPIXELS + 1);
  localparam int RW    = $clog2(TILE_SUBPIXELS);
  localparam int LAT   = tmbc_pkg::DIV_LATENCY;
  localparam int IW    = tmbc_pkg::TILE_IDX_W;
  localparam int OW    = tmbc_pkg::OVL_W;
  localparam int WW    = RW + 1;
  localparam logic [OW-1:0] FULL = OW'(TILE_SUBPIXELS);

  // Configuration registers
  logic [tmbc_pkg::CFG_W-1:0]  stage_cols;
  logic [tmbc_pkg::CFG_W-1:0]  stage_rows;
  logic [tmbc_pkg::SIZE_W-1:0] cols_eff;
  logic [tmbc_pkg::SIZE_W-1:0] rows_eff;
  logic                        cfg_wr;

  // Input stage
  logic                           v1;
  tmbc_pkg::item_ctrl_t           c1;
  logic [tmbc_pkg::POS_MAG_W-1:0] x1;
  logic [tmbc_pkg::POS_MAG_W-1:0] y1;

  // Control shift line beside the divider
  logic [LAT-1:0]       v_pipe;
  tmbc_pkg::item_ctrl_t c_pipe [LAT];

  // Divider outputs (aligned with the last shift stage)
  logic [QW-1:0] qx;
  logic [QW-1:0] qy;
  logic [RW-1:0] rx;
  logic [RW-1:0] ry;
  logic          ex4;
  logic          ey4;
  logic          out_x4;
  logic          out_y4;

  // Map store
  tmbc_pkg::map_wr_t map_wr;
  logic [3:0]        map_bits;
  logic              clearing;

  // Window stage
  logic          q5;
  logic          neg_x5;
  logic          neg_y5;
  logic          out_x5;
  logic          out_y5;
  logic          ex5;
  logic          ey5;
  logic [RW-1:0] rx5;
  logic [RW-1:0] ry5;
  logic          par_x5;
  logic          par_y5;

  // Result logic
  logic          s00, s01, s10, s11;
  logic          col_a, col_b, row_a, row_b;
  logic [WW-1:0] w_a;
  logic [WW-1:0] h_a;
  logic          blocked_next;
  logic [OW-1:0] ol_next, or_next, ot_next, ob_next;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_cols <= '0;
      stage_rows <= '0;
    end else if (cfg_wr) begin
      case (paddr[2])
        tmbc_pkg::REG_STAGE_COLS: stage_cols <= pwdata[tmbc_pkg::CFG_W-1:0];
        tmbc_pkg::REG_STAGE_ROWS: stage_rows <= pwdata[tmbc_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      tmbc_pkg::REG_STAGE_COLS: prdata = tmbc_pkg::APB_DATA_W'(stage_cols);
      tmbc_pkg::REG_STAGE_ROWS: prdata = tmbc_pkg::APB_DATA_W'(stage_rows);
      default:                  prdata = '0;
    endcase
  end

  // Zero or oversized selects the maximum
  assign cols_eff = (stage_cols == '0 ||
                     tmbc_pkg::SIZE_W'(stage_cols) > tmbc_pkg::SIZE_W'(MAX_COLS))
                    ? tmbc_pkg::SIZE_W'(MAX_COLS) : tmbc_pkg::SIZE_W'(stage_cols);
  assign rows_eff = (stage_rows == '0 ||
                     tmbc_pkg::SIZE_W'(stage_rows) > tmbc_pkg::SIZE_W'(MAX_ROWS))
                    ? tmbc_pkg::SIZE_W'(MAX_ROWS) : tmbc_pkg::SIZE_W'(stage_rows);

  // ---------------- input stage ----------------
  assign busy = clearing;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    c1.op    <= op;
    c1.neg_x <= box_x[tmbc_pkg::POS_W-1];
    c1.neg_y <= box_y[tmbc_pkg::POS_W-1];
    c1.col   <= tile_col;
    c1.row   <= tile_row;
    c1.solid <= tile_solid;
    x1       <= box_x[tmbc_pkg::POS_MAG_W-1:0];
    y1       <= box_y[tmbc_pkg::POS_MAG_W-1:0];
  end

  // ---------------- divider stages ----------------
  tmbc_div #(.TILE(TILE_SUBPIXELS)) u_div_x (.clk(clk), .x(x1), .q(qx), .r(rx));
  tmbc_div #(.TILE(TILE_SUBPIXELS)) u_div_y (.clk(clk), .x(y1), .q(qy), .r(ry));

  always_ff @(posedge clk) begin
    if (rst) begin
      v_pipe <= '0;
    end else begin
      v_pipe <= {v_pipe[LAT-2:0], v1};
    end
  end

  always_ff @(posedge clk) begin
    c_pipe[0] <= c1;
    for (int i = 1; i < LAT; i++) begin
      c_pipe[i] <= c_pipe[i-1];
    end
  end

  // Box straddles a second tile when the offset is nonzero; outside when the last
  // covered tile index reaches the stage size
  assign ex4    = |rx;
  assign ey4    = |ry;
  assign out_x4 = (IW'(qx) + IW'(ex4)) >= IW'(cols_eff);
  assign out_y4 = (IW'(qy) + IW'(ey4)) >= IW'(rows_eff);

  // ---------------- map store: writes and window read in item order ----------------
  assign map_wr.en    = v_pipe[LAT-1] && (c_pipe[LAT-1].op == tmbc_pkg::OP_WRITE);
  assign map_wr.col   = c_pipe[LAT-1].col;
  assign map_wr.row   = c_pipe[LAT-1].row;
  assign map_wr.solid = c_pipe[LAT-1].solid;

  tmbc_map #(
    .MAX_COLS(MAX_COLS),
    .MAX_ROWS(MAX_ROWS)
  ) u_map (
    .clk      (clk),
    .rst      (rst),
    .wr       (map_wr),
    .rd_col   (IW'(qx)),
    .rd_row   (IW'(qy)),
    .rd_bits  (map_bits),
    .clearing (clearing)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      q5 <= 1'b0;
    end else begin
      q5 <= v_pipe[LAT-1] && (c_pipe[LAT-1].op == tmbc_pkg::OP_QUERY);
    end
  end

  always_ff @(posedge clk) begin
    neg_x5 <= c_pipe[LAT-1].neg_x;
    neg_y5 <= c_pipe[LAT-1].neg_y;
    out_x5 <= out_x4;
    out_y5 <= out_y4;
    ex5    <= ex4;
    ey5    <= ey4;
    rx5    <= rx;
    ry5    <= ry;
    par_x5 <= qx[0];
    par_y5 <= qy[0];
  end

  // ---------------- overlap evaluation ----------------
  // Window tile (row a/b, col a/b) sits in the bank of its own parity
  assign s00 = map_bits[{par_y5,  par_x5}];
  assign s01 = map_bits[{par_y5,  ~par_x5}];
  assign s10 = map_bits[{~par_y5, par_x5}];
  assign s11 = map_bits[{~par_y5, ~par_x5}];

  // Solid tiles per window column and row; second column/row only when straddling
  assign col_a = s00 || (ey5 && s10);
  assign col_b = ex5 && (s01 || (ey5 && s11));
  assign row_a = s00 || (ex5 && s01);
  assign row_b = ey5 && (s10 || (ex5 && s11));

  assign w_a = WW'(TILE_SUBPIXELS) - WW'(rx5);
  assign h_a = WW'(TILE_SUBPIXELS) - WW'(ry5);

  always_comb begin
    blocked_next = 1'b0;
    ol_next      = '0;
    or_next      = '0;
    ot_next      = '0;
    ob_next      = '0;
    if (neg_x5 || neg_y5) begin
      blocked_next = 1'b1;
      ol_next      = neg_x5 ? FULL : '0;
      ot_next      = neg_y5 ? FULL : '0;
    end else if (out_x5 || out_y5) begin
      blocked_next = 1'b1;
      or_next      = out_x5 ? FULL : '0;
      ob_next      = out_y5 ? FULL : '0;
    end else begin
      blocked_next = col_a || col_b;
      ol_next      = col_a ? OW'(w_a) : '0;
      ot_next      = row_a ? OW'(h_a) : '0;
      // aligned box: the left column also holds the right edge
      or_next      = ex5 ? (col_b ? OW'(WW'(rx5)) : '0) : ol_next;
      ob_next      = ey5 ? (row_b ? OW'(WW'(ry5)) : '0) : ot_next;
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= q5;
    end
  end

  always_ff @(posedge clk) begin
    blocked        <= blocked_next;
    left_overlap   <= ol_next;
    right_overlap  <= or_next;
    top_overlap    <= ot_next;
    bottom_overlap <= ob_next;
  end

endmodule

[hdl/tmbc_div.sv]
// Pipelined divide by the tile size: quotient and remainder of a 12-bit value.
// Three register stages (tmbc_pkg::DIV_LATENCY); uses tmbc_pkg constants.
module tmbc_div #(
  parameter int TILE = 16
) (
  input  logic                           clk,
  input  logic [tmbc_pkg::POS_MAG_W-1:0] x,
  output logic [$clog2(((1 << tmbc_pkg::POS_MAG_W) - 1) / TILE + 1)-1:0] q,
  output logic [$clog2(TILE)-1:0]        r
);

  localparam int QMAX   = ((1 << tmbc_pkg::POS_MAG_W) - 1) / TILE;
  localparam int QW     = $clog2(QMAX + 1);
  localparam int RW     = $clog2(TILE);
  localparam int REM_EW = RW + 1;
  localparam int PROD_W = tmbc_pkg::POS_MAG_W + tmbc_pkg::RECIP_W;
  localparam logic [tmbc_pkg::RECIP_W-1:0] RECIP =
    tmbc_pkg::RECIP_W'((1 << tmbc_pkg::RECIP_SHIFT) / TILE);

  logic [PROD_W-1:0]              prod_a;
  logic [tmbc_pkg::POS_MAG_W-1:0] x_a;
  logic [QW-1:0]                  qe_b;
  logic [REM_EW-1:0]              rem_b;
  logic                           fix_b;

  // Stage A: multiply by the reciprocal
  always_ff @(posedge clk) begin
    prod_a <= PROD_W'(x) * PROD_W'(RECIP);
    x_a    <= x;
  end

  // Stage B: estimate is exact or one low; remainder below twice the tile
  always_ff @(posedge clk) begin
    qe_b  <= prod_a[tmbc_pkg::RECIP_SHIFT +: QW];
    rem_b <= REM_EW'(x_a - tmbc_pkg::POS_MAG_W'(prod_a[tmbc_pkg::RECIP_SHIFT +: QW] * TILE));
  end

  // Stage C: one compare and subtract
  assign fix_b = (rem_b >= REM_EW'(TILE));

  always_ff @(posedge clk) begin
    q <= qe_b + QW'(fix_b);
    r <= RW'(fix_b ? rem_b - REM_EW'(TILE) : rem_b);
  end

endmodule

[hdl/tmbc_map.sv]
// Solidity map store: four banks split by row and column parity so all four tiles of a
// 2x2 window are read together. Clears itself after reset. Uses tmbc_pkg types.
module tmbc_map #(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  tmbc_pkg::map_wr_t               wr,
  input  logic [tmbc_pkg::TILE_IDX_W-1:0] rd_col,
  input  logic [tmbc_pkg::TILE_IDX_W-1:0] rd_row,
  output wire  [3:0]                      rd_bits,  // index {row parity, col parity}
  output logic                            clearing
);

  localparam int HALF_COLS = (MAX_COLS + 1) / 2;
  localparam int HALF_ROWS = (MAX_ROWS + 1) / 2;
  localparam int CHW       = (HALF_COLS > 1) ? $clog2(HALF_COLS) : 1;
  localparam int RHW       = (HALF_ROWS > 1) ? $clog2(HALF_ROWS) : 1;
  localparam int AW        = CHW + RHW;
  localparam int DEPTH     = 1 << AW;

  logic [AW-1:0]                   clr_addr;
  logic [tmbc_pkg::TILE_IDX_W-1:0] wr_col_ext;
  logic [tmbc_pkg::TILE_IDX_W-1:0] wr_row_ext;
  logic                            wr_ok;
  logic [1:0]                      wr_bank;
  logic [AW-1:0]                   wr_addr;

  // Clearing sweep, one address of every bank per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == AW'(DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // Write decode; tiles outside the map are dropped
  assign wr_col_ext = tmbc_pkg::TILE_IDX_W'(wr.col);
  assign wr_row_ext = tmbc_pkg::TILE_IDX_W'(wr.row);
  assign wr_ok      = wr.en && (wr_col_ext < tmbc_pkg::TILE_IDX_W'(MAX_COLS))
                            && (wr_row_ext < tmbc_pkg::TILE_IDX_W'(MAX_ROWS));
  assign wr_bank    = {wr.row[0], wr.col[0]};
  assign wr_addr    = {wr_row_ext[RHW:1], wr_col_ext[CHW:1]};

  for (genvar b = 0; b < 4; b++) begin : g_bank
    localparam int PX = b % 2;
    localparam int PY = b / 2;

    logic                            mem [DEPTH];
    logic [tmbc_pkg::TILE_IDX_W-1:0] col_sel;
    logic [tmbc_pkg::TILE_IDX_W-1:0] row_sel;
    logic [AW-1:0]                   rd_addr;
    logic [AW-1:0]                   waddr;
    logic                            we;
    logic                            wdata;
    logic                            rd_q;

    // This bank holds the window tile whose parity matches; step one tile if needed
    assign col_sel = rd_col + tmbc_pkg::TILE_IDX_W'(rd_col[0] ^ 1'(PX));
    assign row_sel = rd_row + tmbc_pkg::TILE_IDX_W'(rd_row[0] ^ 1'(PY));
    assign rd_addr = {row_sel[RHW:1], col_sel[CHW:1]};

    assign we    = clearing || (wr_ok && (wr_bank == 2'(b)));
    assign waddr = clearing ? clr_addr : wr_addr;
    assign wdata = clearing ? 1'b0 : wr.solid;

    always_ff @(posedge clk) begin
      if (we) begin
        mem[waddr] <= wdata;
      end
      rd_q <= mem[rd_addr];
    end

    assign rd_bits[b] = rd_q;
  end

endmodule

[bench/tile_map_box_collision_unit_tb.sv]
// Self-checking bench for tile_map_box_collision_unit: map writes, box queries, APB stage setup.
// Depends on tmbc_pkg and the RTL top level; predicts every overlap result internally.
module tile_map_box_collision_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TILE_SP        = 16;
  localparam int N_COLS         = 64;
  localparam int N_ROWS         = 64;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int N_PHASES       = 8;
  localparam int PHASE_ITEMS    = 118;
  localparam int DRAIN_CYCLES   = 8;

  typedef struct packed {
    logic                       blocked;
    logic [tmbc_pkg::OVL_W-1:0] ovl_left;
    logic [tmbc_pkg::OVL_W-1:0] ovl_right;
    logic [tmbc_pkg::OVL_W-1:0] ovl_top;
    logic [tmbc_pkg::OVL_W-1:0] ovl_bottom;
  } overlap_t;

  typedef struct packed {
    logic                              op;
    logic [tmbc_pkg::MAP_IDX_W-1:0]    col;
    logic [tmbc_pkg::MAP_IDX_W-1:0]    row;
    logic                              solid;
    logic signed [tmbc_pkg::POS_W-1:0] x;
    logic signed [tmbc_pkg::POS_W-1:0] y;
  } map_item_t;

  // Tracks the solidity map and stage size, predicts overlaps, checks result beats
  class collision_scoreboard;
    bit                         solid_tiles[N_COLS*N_ROWS];
    logic [tmbc_pkg::CFG_W-1:0] cols_reg;
    logic [tmbc_pkg::CFG_W-1:0] rows_reg;
    overlap_t                   pending_overlaps[$];
    int unsigned                n_writes, n_queries, n_blocked, n_checked, n_errors;

    function new();
      foreach (solid_tiles[i]) solid_tiles[i] = 1'b0;
      cols_reg = '0;
      rows_reg = '0;
    endfunction

    function void report(string msg);
      n_errors++;
      if (n_errors <= 10) $display("[%0t] error: %s", $realtime, msg);
    endfunction

    function void set_reg(logic idx, logic [tmbc_pkg::CFG_W-1:0] value);
      if (idx == tmbc_pkg::REG_STAGE_COLS) cols_reg = value;
      else rows_reg = value;
    endfunction

    function int stage_size(logic [tmbc_pkg::CFG_W-1:0] r, int maxv);
      if (r == 0 || r > maxv) return maxv;
      return int'(r);
    endfunction

    function overlap_t predict_overlap(int x, int y);
      overlap_t r;
      int nc, nr, tx, ty, lft, rgt, top, bot, w, h;
      r  = '0;
      nc = stage_size(cols_reg, N_COLS);
      nr = stage_size(rows_reg, N_ROWS);
      if (x < 0 || y < 0) begin
        // off the top/left of the stage
        r.blocked = 1'b1;
        if (x < 0) r.ovl_left = tmbc_pkg::OVL_W'(TILE_SP);
        if (y < 0) r.ovl_top  = tmbc_pkg::OVL_W'(TILE_SP);
      end else if (x + TILE_SP > nc*TILE_SP || y + TILE_SP > nr*TILE_SP) begin
        // past the right/bottom edge
        r.blocked = 1'b1;
        if (x + TILE_SP > nc*TILE_SP) r.ovl_right  = tmbc_pkg::OVL_W'(TILE_SP);
        if (y + TILE_SP > nr*TILE_SP) r.ovl_bottom = tmbc_pkg::OVL_W'(TILE_SP);
      end else begin
        // scan the up-to-2x2 window under the box
        for (ty = y/TILE_SP; ty <= (y+TILE_SP-1)/TILE_SP; ty++) begin
          for (tx = x/TILE_SP; tx <= (x+TILE_SP-1)/TILE_SP; tx++) begin
            if (ty < nr && tx < nc && solid_tiles[ty*N_COLS + tx]) begin
              r.blocked = 1'b1;
              lft = tx*TILE_SP; rgt = lft + TILE_SP;
              top = ty*TILE_SP; bot = top + TILE_SP;
              w = ((x+TILE_SP < rgt) ? x+TILE_SP : rgt) - ((x > lft) ? x : lft);
              h = ((y+TILE_SP < bot) ? y+TILE_SP : bot) - ((y > top) ? y : top);
              if (w > 0 && h > 0) begin
                if (lft <= x && rgt > x && w > r.ovl_left)
                  r.ovl_left = tmbc_pkg::OVL_W'(w);
                if (lft < x+TILE_SP && rgt >= x+TILE_SP && w > r.ovl_right)
                  r.ovl_right = tmbc_pkg::OVL_W'(w);
                if (top <= y && bot > y && h > r.ovl_top)
                  r.ovl_top = tmbc_pkg::OVL_W'(h);
                if (top < y+TILE_SP && bot >= y+TILE_SP && h > r.ovl_bottom)
                  r.ovl_bottom = tmbc_pkg::OVL_W'(h);
              end
            end
          end
        end
      end
      return r;
    endfunction

    // accepted item beat: writes update the map, queries queue a prediction
    function void note_item(map_item_t it);
      overlap_t want;
      if (it.op == tmbc_pkg::OP_WRITE) begin
        n_writes++;
        solid_tiles[int'(it.row)*N_COLS + int'(it.col)] = it.solid;
      end else begin
        n_queries++;
        want = predict_overlap(int'(it.x), int'(it.y));
        if (want.blocked) n_blocked++;
        pending_overlaps.push_back(want);
      end
    endfunction

    function void check_result(overlap_t got);
      overlap_t want;
      if (pending_overlaps.size() == 0) begin
        report($sformatf("result beat with no query outstanding: blk=%0d l=%0d r=%0d t=%0d b=%0d",
                         got.blocked, got.ovl_left, got.ovl_right, got.ovl_top,
                         got.ovl_bottom));
        return;
      end
      want = pending_overlaps.pop_front();
      n_checked++;
      if (got.blocked !== want.blocked || got.ovl_left !== want.ovl_left ||
          got.ovl_right !== want.ovl_right || got.ovl_top !== want.ovl_top ||
          got.ovl_bottom !== want.ovl_bottom)
        report($sformatf({"overlap mismatch: exp blk=%0d l=%0d r=%0d t=%0d b=%0d, ",
                          "got blk=%0d l=%0d r=%0d t=%0d b=%0d"},
                         want.blocked, want.ovl_left, want.ovl_right, want.ovl_top,
                         want.ovl_bottom, got.blocked, got.ovl_left, got.ovl_right,
                         got.ovl_top, got.ovl_bottom));
    endfunction
  endclass

  // DUT signals
  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              start = 1'b0;
  logic                              busy;
  logic                              op = tmbc_pkg::OP_WRITE;
  logic [tmbc_pkg::MAP_IDX_W-1:0]    tile_col = '0;
  logic [tmbc_pkg::MAP_IDX_W-1:0]    tile_row = '0;
  logic                              tile_solid = 1'b0;
  logic signed [tmbc_pkg::POS_W-1:0] box_x = '0;
  logic signed [tmbc_pkg::POS_W-1:0] box_y = '0;
  logic                              done;
  logic                              blocked;
  logic [tmbc_pkg::OVL_W-1:0]        left_overlap, right_overlap, top_overlap, bottom_overlap;
  logic                              psel = 1'b0;
  logic                              penable = 1'b0;
  logic                              pwrite = 1'b0;
  logic [tmbc_pkg::CFG_ADDR_W-1:0]   paddr = '0;
  logic [tmbc_pkg::APB_DATA_W-1:0]   pwdata = '0;
  logic [tmbc_pkg::APB_DATA_W-1:0]   prdata;
  logic                              pready;

  collision_scoreboard sb = new();

  bit          take_now = 1'b0;
  int unsigned stall_cycles = 0;
  int          idle_pct = 0;
  int          eff_cols, eff_rows, focus_x, focus_y, focus_w, focus_h;

  tile_map_box_collision_unit #(
    .TILE_SUBPIXELS(TILE_SP),
    .MAX_COLS(N_COLS),
    .MAX_ROWS(N_ROWS)
  ) dut (
    .clk(clk), .rst(rst),
    .start(start), .busy(busy),
    .op(op), .tile_col(tile_col), .tile_row(tile_row), .tile_solid(tile_solid),
    .box_x(box_x), .box_y(box_y),
    .done(done), .blocked(blocked),
    .left_overlap(left_overlap), .right_overlap(right_overlap),
    .top_overlap(top_overlap), .bottom_overlap(bottom_overlap),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Sample mid-cycle: what is seen here is what the next rising edge takes
  always @(negedge clk) begin
    overlap_t  got;
    map_item_t it;
    if (!rst) begin
      take_now = start && (busy === 1'b0);
      if (take_now) begin
        it = '{op, tile_col, tile_row, tile_solid, box_x, box_y};
        sb.note_item(it);
      end
      if (done === 1'b1) begin
        got = '{blocked, left_overlap, right_overlap, top_overlap, bottom_overlap};
        sb.check_result(got);
      end
      // watchdog on cycles with no beat in either direction
      if (take_now || done === 1'b1) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                 stall_cycles, sb.pending_overlaps.size());
        $display("FAIL");
        $finish;
      end
    end
  end

  // Drive one item beat and hold it until accepted
  task automatic send_item(map_item_t it);
    op         <= it.op;
    tile_col   <= it.col;
    tile_row   <= it.row;
    tile_solid <= it.solid;
    box_x      <= it.x;
    box_y      <= it.y;
    start      <= 1'b1;
    do @(posedge clk); while (!take_now);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  function automatic map_item_t write_item(int col, int row, bit solid);
    map_item_t it;
    it = '{tmbc_pkg::OP_WRITE, col[tmbc_pkg::MAP_IDX_W-1:0], row[tmbc_pkg::MAP_IDX_W-1:0],
           solid, tmbc_pkg::POS_W'($urandom()), tmbc_pkg::POS_W'($urandom())};
    return it;
  endfunction

  function automatic map_item_t query_item(int x, int y);
    map_item_t it;
    it = '{tmbc_pkg::OP_QUERY, tmbc_pkg::MAP_IDX_W'($urandom()),
           tmbc_pkg::MAP_IDX_W'($urandom()), 1'($urandom()),
           x[tmbc_pkg::POS_W-1:0], y[tmbc_pkg::POS_W-1:0]};
    return it;
  endfunction

  // One position coordinate, biased toward the focus window and the stage edges
  function automatic int pick_coord(int kind, int origin, int span, int n_tiles);
    case (kind)
      0: return origin*TILE_SP + $urandom_range(0, span*TILE_SP) - 8;
      1: return $urandom_range(0, n_tiles*TILE_SP - TILE_SP);
      2: begin
        if ($urandom_range(1)) return $urandom_range(0, 20) - 20;
        return n_tiles*TILE_SP - TILE_SP + $urandom_range(0, 20) - 10;
      end
      default: return int'($signed(tmbc_pkg::POS_W'($urandom())));
    endcase
  endfunction

  function automatic map_item_t random_item();
    int k;
    k = $urandom_range(99);
    if ($urandom_range(99) < 40) begin
      if ($urandom_range(99) < 75)
        return write_item(focus_x + $urandom_range(0, focus_w-1),
                          focus_y + $urandom_range(0, focus_h-1),
                          $urandom_range(99) < 65);
      return write_item($urandom_range(0, 63), $urandom_range(0, 63),
                        1'($urandom_range(1)));
    end
    k = (k < 55) ? 0 : (k < 75) ? 1 : (k < 90) ? 2 : 3;
    return query_item(pick_coord(k, focus_x, focus_w, eff_cols),
                      pick_coord(k, focus_y, focus_h, eff_rows));
  endfunction

  task automatic apb_write(logic idx, logic [tmbc_pkg::CFG_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= ($urandom() & ~32'h7F) | value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    sb.set_reg(idx, value);
  endtask

  task automatic apb_check(logic idx, logic [tmbc_pkg::CFG_W-1:0] value);
    logic [tmbc_pkg::APB_DATA_W-1:0] rd;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    rd = prdata;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd !== tmbc_pkg::APB_DATA_W'(value))
      sb.report($sformatf("register %0d readback: exp %0d, got %0h", idx, value, rd));
  endtask

  task automatic set_stage(logic [tmbc_pkg::CFG_W-1:0] cols,
                           logic [tmbc_pkg::CFG_W-1:0] rows);
    apb_write(tmbc_pkg::REG_STAGE_COLS, cols);
    apb_write(tmbc_pkg::REG_STAGE_ROWS, rows);
    apb_check(tmbc_pkg::REG_STAGE_COLS, cols);
    apb_check(tmbc_pkg::REG_STAGE_ROWS, rows);
    eff_cols = (cols == 0 || cols > N_COLS) ? N_COLS : int'(cols);
    eff_rows = (rows == 0 || rows > N_ROWS) ? N_ROWS : int'(rows);
    focus_w  = (eff_cols > 6) ? 6 : eff_cols;
    focus_h  = (eff_rows > 6) ? 6 : eff_rows;
    focus_x  = $urandom_range(0, eff_cols - focus_w);
    focus_y  = $urandom_range(0, eff_rows - focus_h);
  endtask

  // Wait out in-flight results, plus the pipeline depth for trailing writes
  task automatic drain();
    start <= 1'b0;
    while (sb.pending_overlaps.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic [tmbc_pkg::CFG_W-1:0] stage_cols_set[N_PHASES] =
      '{7'd0, 7'd1, 7'd64, 7'd127, 7'd3, 7'd13, 7'd0, 7'd40};
    logic [tmbc_pkg::CFG_W-1:0] stage_rows_set[N_PHASES] =
      '{7'd0, 7'd1, 7'd64, 7'd65, 7'd7, 7'd2, 7'd100, 7'd0};
    map_item_t                  directed[$];

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int p = 0; p < N_PHASES; p++) begin
      if (p != 0) drain();
      if (p == N_PHASES-1)
        set_stage(tmbc_pkg::CFG_W'($urandom_range(0, 127)),
                  tmbc_pkg::CFG_W'($urandom_range(0, 127)));
      else set_stage(stage_cols_set[p], stage_rows_set[p]);

      if (p == 0) begin
        // directed: corners, off-stage sides, 2x2 windows, free box, cleared tile
        directed = '{write_item(0, 0, 1), write_item(63, 63, 1), write_item(5, 5, 1),
                     write_item(6, 5, 1), write_item(5, 6, 1), write_item(6, 6, 0),
                     query_item(0, 0), query_item(-4096, -4096), query_item(-1, 100),
                     query_item(100, -1), query_item(4095, 4095), query_item(1009, 0),
                     query_item(0, 1009), query_item(1008, 1008), query_item(88, 88),
                     query_item(80, 88), query_item(300, 300), write_item(5, 5, 0),
                     query_item(88, 88), query_item(95, 81), write_item(0, 0, 0),
                     query_item(1, 0)};
        foreach (directed[i]) send_item(directed[i]);
      end

      // random items; idling density changes in stretches, none in the final phase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 32 == 0) idle_pct = (p == N_PHASES-1) ? 0 : 15 * $urandom_range(0, 2);
        send_item(random_item());
      end
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("ran %0d map writes and %0d box queries (%0d blocked) over %0d stage sizes",
             sb.n_writes, sb.n_queries, sb.n_blocked, N_PHASES);
    $display("%0d results checked, %0d errors", sb.n_checked, sb.n_errors);
    if (sb.n_errors == 0 && sb.pending_overlaps.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[files.f]
hdl/tmbc_pkg.sv
hdl/tmbc_div.sv
hdl/tmbc_map.sv
hdl/tile_map_box_collision_unit.sv
bench/tile_map_box_collision_unit_tb.sv
